FILE: design/ipcw_pkg.sv
package ipcw_pkg;

   localparam int HEADER_BYTES = 4;
   localparam int OFFSET_BITS  = 16;
   localparam int LENGTH_BITS  = 16;
   localparam int INDEX_BITS   = 3;
   localparam int CRIT_BIT     = 7;

   localparam logic [INDEX_BITS-1:0]  HDR_FULL  = INDEX_BITS'(HEADER_BYTES);
   localparam logic [INDEX_BITS-1:0]  HDR_LAST  = INDEX_BITS'(HEADER_BYTES - 1);
   localparam logic [INDEX_BITS-1:0]  HDR_NEXT  = INDEX_BITS'(0);
   localparam logic [INDEX_BITS-1:0]  HDR_FLAGS = INDEX_BITS'(1);
   localparam logic [INDEX_BITS-1:0]  HDR_LENHI = INDEX_BITS'(2);
   localparam logic [OFFSET_BITS-1:0] AREA_LIMIT = {OFFSET_BITS{1'b1}};
   localparam logic [LENGTH_BITS-1:0] HDR_LEN    = LENGTH_BITS'(HEADER_BYTES);

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_BAD_LENGTH = 2'd1,
      STATUS_TRUNCATED  = 2'd2,
      STATUS_TOO_LONG   = 2'd3
   } status_type;

endpackage

FILE: design/ike_payload_chain_walker.sv
// a result appears in the rsp register in the cycle after its byte is accepted
// throughput: one byte per cycle; req_ready drops only while a held result is not taken
// the whole walk step is one combinational pass from the chain state to the result register
// reset (synchronous, active high) empties the result register and halts the walk
// until a byte marked area_first arrives
module ike_payload_chain_walker
   import ipcw_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_data_byte,
   input  logic                   req_area_first,
   input  logic                   req_area_last,
   input  logic [7:0]             req_first_type,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [1:0]             rsp_status,
   output logic [7:0]             rsp_payload_type,
   output logic [7:0]             rsp_next_type,
   output logic                   rsp_critical_flag,
   output logic [LENGTH_BITS-1:0] rsp_body_length,
   output logic [OFFSET_BITS-1:0] rsp_body_offset
);

   logic [INDEX_BITS-1:0]  header_index_ff, header_index_in;
   logic [7:0]             current_type_ff, current_type_in;
   logic [7:0]             pending_next_ff, pending_next_in;
   logic                   critical_seen_ff, critical_seen_in;
   logic [7:0]             length_high_ff, length_high_in;
   logic [LENGTH_BITS-1:0] body_remaining_ff, body_remaining_in;
   logic [OFFSET_BITS-1:0] area_offset_ff, area_offset_in;
   logic [OFFSET_BITS-1:0] payload_start_ff, payload_start_in;
   logic                   halted_ff, halted_in;

   logic                   rsp_valid_ff;
   status_type             rsp_status_ff, rsp_status_in;
   logic [7:0]             rsp_type_ff, rsp_type_in;
   logic [7:0]             rsp_next_ff, rsp_next_in;
   logic                   rsp_crit_ff, rsp_crit_in;
   logic [LENGTH_BITS-1:0] rsp_len_ff, rsp_len_in;
   logic [OFFSET_BITS-1:0] rsp_off_ff, rsp_off_in;
   logic                   emit;

   logic                   req_accept;

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      logic                   stop;
      logic [LENGTH_BITS-1:0] plen;
      logic [OFFSET_BITS-1:0] off_next;

      header_index_in   = header_index_ff;
      current_type_in   = current_type_ff;
      pending_next_in   = pending_next_ff;
      critical_seen_in  = critical_seen_ff;
      length_high_in    = length_high_ff;
      body_remaining_in = body_remaining_ff;
      area_offset_in    = area_offset_ff;
      payload_start_in  = payload_start_ff;
      halted_in         = halted_ff;
      emit              = 1'b0;
      rsp_status_in     = STATUS_OK;
      rsp_type_in       = current_type_ff;
      rsp_next_in       = '0;
      rsp_crit_in       = 1'b0;
      rsp_len_in        = '0;
      rsp_off_in        = '0;
      stop              = 1'b0;
      plen              = '0;
      off_next          = '0;

      // new area restarts the walk
      if (req_area_first) begin
         current_type_in   = req_first_type;
         area_offset_in    = '0;
         header_index_in   = '0;
         body_remaining_in = '0;
         pending_next_in   = '0;
         critical_seen_in  = 1'b0;
         length_high_in    = '0;
         payload_start_in  = '0;
         halted_in         = (req_first_type == 8'd0);
      end

      if (!halted_in) begin
         off_next = area_offset_in + OFFSET_BITS'(1);
         if (area_offset_in == AREA_LIMIT) begin
            emit          = 1'b1;
            rsp_status_in = STATUS_TOO_LONG;
            rsp_type_in   = current_type_in;
            halted_in     = 1'b1;
            stop          = 1'b1;
         end else if (header_index_in < HDR_FULL) begin
            if (header_index_in == HDR_NEXT) begin
               pending_next_in = req_data_byte;
            end else if (header_index_in == HDR_FLAGS) begin
               critical_seen_in = req_data_byte[CRIT_BIT];
            end else if (header_index_in == HDR_LENHI) begin
               length_high_in = req_data_byte;
            end
            if (header_index_in == HDR_LAST) begin
               plen = {length_high_in, req_data_byte};
               if (plen < HDR_LEN) begin
                  emit          = 1'b1;
                  rsp_status_in = STATUS_BAD_LENGTH;
                  rsp_type_in   = current_type_in;
                  halted_in     = 1'b1;
                  stop          = 1'b1;
               end else begin
                  body_remaining_in = plen - HDR_LEN;
                  payload_start_in  = off_next;
                  header_index_in   = HDR_FULL;
                  if (body_remaining_in == '0) begin
                     emit              = 1'b1;
                     rsp_type_in       = current_type_in;
                     rsp_next_in       = pending_next_in;
                     rsp_crit_in       = critical_seen_in;
                     rsp_len_in        = '0;
                     rsp_off_in        = payload_start_in;
                     current_type_in   = pending_next_in;
                     header_index_in   = '0;
                     halted_in         = (pending_next_in == 8'd0);
                  end
               end
            end else begin
               header_index_in = header_index_in + INDEX_BITS'(1);
            end
         end else begin
            if (body_remaining_in != '0) begin
               body_remaining_in = body_remaining_in - LENGTH_BITS'(1);
            end
            if (body_remaining_in == '0) begin
               emit            = 1'b1;
               rsp_type_in     = current_type_in;
               rsp_next_in     = pending_next_in;
               rsp_crit_in     = critical_seen_in;
               rsp_len_in      = LENGTH_BITS'(off_next - payload_start_in);
               rsp_off_in      = payload_start_in;
               current_type_in = pending_next_in;
               header_index_in = '0;
               halted_in       = (pending_next_in == 8'd0);
            end
         end

         if (!stop) begin
            area_offset_in = off_next;
            // area closes while still active
            if (req_area_last && !halted_in) begin
               if (!emit && (header_index_in != '0 || body_remaining_in != '0)) begin
                  emit          = 1'b1;
                  rsp_status_in = STATUS_TRUNCATED;
                  rsp_type_in   = current_type_in;
                  rsp_next_in   = '0;
                  rsp_crit_in   = 1'b0;
                  rsp_len_in    = '0;
                  rsp_off_in    = '0;
               end
               halted_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_index_ff   <= '0;
         current_type_ff   <= '0;
         pending_next_ff   <= '0;
         critical_seen_ff  <= 1'b0;
         length_high_ff    <= '0;
         body_remaining_ff <= '0;
         area_offset_ff    <= '0;
         payload_start_ff  <= '0;
         halted_ff         <= 1'b1;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (req_accept) begin
            header_index_ff   <= header_index_in;
            current_type_ff   <= current_type_in;
            pending_next_ff   <= pending_next_in;
            critical_seen_ff  <= critical_seen_in;
            length_high_ff    <= length_high_in;
            body_remaining_ff <= body_remaining_in;
            area_offset_ff    <= area_offset_in;
            payload_start_ff  <= payload_start_in;
            halted_ff         <= halted_in;
            rsp_valid_ff      <= emit;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (req_accept && emit) begin
         rsp_status_ff <= rsp_status_in;
         rsp_type_ff   <= rsp_type_in;
         rsp_next_ff   <= rsp_next_in;
         rsp_crit_ff   <= rsp_crit_in;
         rsp_len_ff    <= rsp_len_in;
         rsp_off_ff    <= rsp_off_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_payload_type  = rsp_type_ff;
   assign rsp_next_type     = rsp_next_ff;
   assign rsp_critical_flag = rsp_crit_ff;
   assign rsp_body_length   = rsp_len_ff;
   assign rsp_body_offset   = rsp_off_ff;

`ifndef SYNTHESIS
   a_error_halts: assert property (@(posedge clock) disable iff (reset)
      (req_accept && emit && rsp_status_in != STATUS_OK) |=> halted_ff)
      else $error("walk not halted after error transaction");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      header_index_ff <= HDR_FULL)
      else $error("header index out of range");

   a_body_open: assert property (@(posedge clock) disable iff (reset)
      (header_index_ff == HDR_FULL) |-> (body_remaining_ff != '0))
      else $error("body state with nothing remaining");
`endif

endmodule
